@@ design/itcb_pkg.sv @@
// Shared types and constants for the integer to custom base text converter.
`default_nettype none

package itcb_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_LENGTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_0_3    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_4_7    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_8_11   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_12_15  = 3'd4;

    // Field widths
    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 32;
    localparam int NUM_DIGIT_SLOTS = 32;
    localparam int COUNT_W = 6;

    // Reset values of the configuration registers
    localparam logic [RADIX_W-1:0]    RST_BASE_LENGTH = 5'd10;
    localparam logic [CFG_DATA_W-1:0] RST_CHARS_0_3   = 32'h3332_3130;
    localparam logic [CFG_DATA_W-1:0] RST_CHARS_4_7   = 32'h3736_3534;
    localparam logic [CFG_DATA_W-1:0] RST_CHARS_8_11  = 32'h4241_3938;
    localparam logic [CFG_DATA_W-1:0] RST_CHARS_12_15 = 32'h4645_4443;

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BAD,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // Status from the digit table to the sequencer
    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic               table_ok;
    } table_status_t;

endpackage

`default_nettype wire

@@ design/itcb_divstep.sv @@
// Shared division unit: eight long-division steps of one dividend byte by the radix.
`default_nettype none

module itcb_divstep (
    input  wire logic [itcb_pkg::DIGIT_W-1:0] rem_in,
    input  wire logic [7:0]                   byte_in,
    input  wire logic [itcb_pkg::RADIX_W-1:0] radix,
    output logic      [7:0]                   quo_out,
    output logic      [itcb_pkg::DIGIT_W-1:0] rem_out
);

    // Shift in one dividend bit a step, subtract the radix when it fits
    always_comb
    begin
        logic [itcb_pkg::RADIX_W-1:0] r;
        r = {1'b0, rem_in};
        quo_out = '0;
        for (int k = 7; k >= 0; k--)
        begin
            r = {r[itcb_pkg::DIGIT_W-1:0], byte_in[k]};
            if (r >= radix)
            begin
                r = r - radix;
                quo_out[k] = 1'b1;
            end
        end
        rem_out = r[itcb_pkg::DIGIT_W-1:0];
    end

endmodule

`default_nettype wire

@@ design/itcb_table.sv @@
// Configuration registers, digit character lookup and table validity check.
`default_nettype none

module itcb_table #(
    parameter int MAX_BASE = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [itcb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [itcb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [itcb_pkg::DIGIT_W-1:0]      digit,
    output logic      [itcb_pkg::CHAR_W-1:0]       digit_char,
    output itcb_pkg::table_status_t                status
);

    localparam int NUM_CHARS = 16;

    logic [itcb_pkg::RADIX_W-1:0]    base_length_reg;
    logic [itcb_pkg::CFG_DATA_W-1:0] chars_reg [4];
    logic [itcb_pkg::CHAR_W-1:0]     chars [NUM_CHARS];
    logic                            dup;

    // Take configuration writes; ignore indexes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_length_reg <= itcb_pkg::RST_BASE_LENGTH;
            chars_reg[0]    <= itcb_pkg::RST_CHARS_0_3;
            chars_reg[1]    <= itcb_pkg::RST_CHARS_4_7;
            chars_reg[2]    <= itcb_pkg::RST_CHARS_8_11;
            chars_reg[3]    <= itcb_pkg::RST_CHARS_12_15;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                itcb_pkg::REG_BASE_LENGTH:
                    base_length_reg <= cfg_data[itcb_pkg::RADIX_W-1:0];
                itcb_pkg::REG_CHARS_0_3:   chars_reg[0] <= cfg_data;
                itcb_pkg::REG_CHARS_4_7:   chars_reg[1] <= cfg_data;
                itcb_pkg::REG_CHARS_8_11:  chars_reg[2] <= cfg_data;
                itcb_pkg::REG_CHARS_12_15: chars_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Split the words into one character per digit value, lowest byte first
    for (genvar g = 0; g < NUM_CHARS; g++)
    begin : g_chars
        assign chars[g] = chars_reg[g / 4][(g % 4) * 8 +: 8];
    end

    assign digit_char = chars[digit];

    // Flag any two equal characters among the digits in use
    always_comb
    begin
        dup = 1'b0;
        for (int i = 0; i < MAX_BASE; i++)
        begin
            for (int j = i + 1; j < MAX_BASE; j++)
            begin
                if ((itcb_pkg::RADIX_W'(j) < base_length_reg) && (chars[i] == chars[j]))
                begin
                    dup = 1'b1;
                end
            end
        end
    end

    assign status.radix    = base_length_reg;
    assign status.table_ok = (base_length_reg >= itcb_pkg::RADIX_W'(2))
                          && (base_length_reg <= itcb_pkg::RADIX_W'(MAX_BASE))
                          && !dup;

endmodule

`default_nettype wire

@@ design/integer_to_custom_base_digits.sv @@
// Top level: sequencer, digit stack and output register of the base converter.
//
// Converts one signed 32-bit value into its text in a configured base.
// Raise start with value for one cycle while busy is low; that beat is
// accepted. busy stays high until the last character has been issued.
// Characters come out one per cycle on out_char, each marked by out_valid
// for exactly one cycle, most significant digit first, with a leading '-'
// for negatives; is_last marks the final character. The receiver cannot
// stall, so every strobed character must be taken when shown.
// If the digit table is invalid, the sequencer passes through ST_BAD and one
// registered beat with base_invalid and is_last set and out_char zero is issued.
// Division: the shared divider retires eight dividend bits a cycle, so each
// digit takes one pass over the whole 32-bit quotient; the digits are then
// issued, after a sign beat for negatives. The last beat is shown in the
// same cycle that busy drops.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once; the
// user must make them only while busy is low: the block does not enforce it.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and loads
// the decimal table "0123456789ABCDEF" with base length 10.
`default_nettype none

module integer_to_custom_base_digits #(
    parameter int MAX_BASE = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [itcb_pkg::VALUE_W-1:0] value,
    input  wire logic                              cfg_we,
    input  wire logic [itcb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [itcb_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                   out_valid,
    output logic      [itcb_pkg::CHAR_W-1:0]       out_char,
    output logic                                   is_last,
    output logic                                   base_invalid
);

    itcb_pkg::state_t state_reg, state_next;
    logic [itcb_pkg::VALUE_W-1:0] quo_reg, quo_next;
    logic [itcb_pkg::DIGIT_W-1:0] rem_reg, rem_next;
    logic [1:0]                   step_reg, step_next;
    logic [itcb_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic                         neg_reg, neg_next;
    logic [itcb_pkg::DIGIT_W-1:0] stack_reg [itcb_pkg::NUM_DIGIT_SLOTS];
    logic                         push, pop;

    logic                         out_valid_reg, out_valid_next;
    logic [itcb_pkg::CHAR_W-1:0]  out_char_reg, out_char_next;
    logic                         is_last_reg, is_last_next;
    logic                         base_invalid_reg, base_invalid_next;

    logic [7:0]                   quo_byte;
    logic [itcb_pkg::DIGIT_W-1:0] rem_out;
    logic [itcb_pkg::VALUE_W-1:0] quo_shifted;
    logic [itcb_pkg::CHAR_W-1:0]  top_char;
    itcb_pkg::table_status_t      tstat;
    logic                         accept;

    itcb_table #(
        .MAX_BASE(MAX_BASE)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .digit      (stack_reg[0]),
        .digit_char (top_char),
        .status     (tstat)
    );

    itcb_divstep u_div (
        .rem_in  (rem_reg),
        .byte_in (quo_reg[itcb_pkg::VALUE_W-1 -: 8]),
        .radix   (tstat.radix),
        .quo_out (quo_byte),
        .rem_out (rem_out)
    );

    assign quo_shifted = {quo_reg[itcb_pkg::VALUE_W-9:0], quo_byte};
    assign busy        = (state_reg != itcb_pkg::ST_IDLE);
    assign accept      = start && !busy;

    // Hold control state and the output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itcb_pkg::ST_IDLE;
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the working value and output payload
    always_ff @(posedge clk)
    begin
        quo_reg          <= quo_next;
        rem_reg          <= rem_next;
        neg_reg          <= neg_next;
        out_char_reg     <= out_char_next;
        is_last_reg      <= is_last_next;
        base_invalid_reg <= base_invalid_next;
    end

    // Push digits at the bottom, pop from the bottom: the last pushed is the most significant
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_reg[0] <= rem_out;
            for (int k = 1; k < itcb_pkg::NUM_DIGIT_SLOTS; k++)
            begin
                stack_reg[k] <= stack_reg[k-1];
            end
        end
        else if (pop)
        begin
            for (int k = 0; k < itcb_pkg::NUM_DIGIT_SLOTS - 1; k++)
            begin
                stack_reg[k] <= stack_reg[k+1];
            end
        end
    end

    // Sequence the division passes and the character beats
    always_comb
    begin
        state_next        = state_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        step_next         = step_reg;
        cnt_next          = cnt_reg;
        neg_next          = neg_reg;
        push              = 1'b0;
        pop               = 1'b0;
        out_valid_next    = 1'b0;
        out_char_next     = out_char_reg;
        is_last_next      = is_last_reg;
        base_invalid_next = base_invalid_reg;

        unique case (state_reg)
            itcb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next  = value[itcb_pkg::VALUE_W-1];
                    quo_next  = value[itcb_pkg::VALUE_W-1] ? (32'd0 - value) : value;
                    rem_next  = '0;
                    step_next = '0;
                    cnt_next  = '0;
                    state_next = tstat.table_ok ? itcb_pkg::ST_DIV : itcb_pkg::ST_BAD;
                end
            end
            itcb_pkg::ST_BAD:
            begin
                out_valid_next    = 1'b1;
                out_char_next     = '0;
                is_last_next      = 1'b1;
                base_invalid_next = 1'b1;
                state_next        = itcb_pkg::ST_IDLE;
            end
            itcb_pkg::ST_DIV:
            begin
                quo_next  = quo_shifted;
                rem_next  = rem_out;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    push     = 1'b1;
                    rem_next = '0;
                    cnt_next = cnt_reg + itcb_pkg::COUNT_W'(1);
                    if (quo_shifted == '0)
                    begin
                        state_next = neg_reg ? itcb_pkg::ST_SIGN : itcb_pkg::ST_EMIT;
                    end
                end
            end
            itcb_pkg::ST_SIGN:
            begin
                out_valid_next    = 1'b1;
                out_char_next     = itcb_pkg::MINUS_CHAR;
                is_last_next      = 1'b0;
                base_invalid_next = 1'b0;
                state_next        = itcb_pkg::ST_EMIT;
            end
            itcb_pkg::ST_EMIT:
            begin
                pop               = 1'b1;
                out_valid_next    = 1'b1;
                out_char_next     = top_char;
                is_last_next      = (cnt_reg == itcb_pkg::COUNT_W'(1));
                base_invalid_next = 1'b0;
                cnt_next          = cnt_reg - itcb_pkg::COUNT_W'(1);
                if (cnt_reg == itcb_pkg::COUNT_W'(1))
                begin
                    state_next = itcb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = itcb_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign is_last      = is_last_reg;
    assign base_invalid = base_invalid_reg;

    // A beat only follows a cycle of work
    a_beat_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(busy))
        else $error("output beat without work in progress");

    // The invalid-table beat is a lone, empty, final beat
    a_invalid_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && base_invalid) |-> (is_last && (out_char == '0)))
        else $error("invalid-table beat malformed");

    // Digit count never passes the stack depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= itcb_pkg::COUNT_W'(itcb_pkg::NUM_DIGIT_SLOTS))
        else $error("digit stack overflow");

    // Popping an empty stack never happens
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itcb_pkg::ST_EMIT) |-> (cnt_reg != '0))
        else $error("emit with no digits");

    // An accepted item makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not start work");

endmodule

`default_nettype wire
